FILE: rtl/core/rpn_pkg.sv
package rpn_pkg;

   localparam int STACK_ENTRIES = 64;
   localparam int FRAC_BITS     = 16;

   localparam int DATA_W      = 32;
   localparam int MODE_W      = 4;
   localparam int DEPTH_OUT_W = 7;
   localparam int STATUS_W    = 3;

   localparam int ADDR_W  = $clog2(STACK_ENTRIES);
   localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);
   localparam int LO_W    = DATA_W + FRAC_BITS;
   localparam int CNT_W   = $clog2(LO_W + 1);
   localparam int WIDE_W  = 2 * DATA_W + 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH  = 4'd0,
      MODE_ADD   = 4'd1,
      MODE_SUB   = 4'd2,
      MODE_MUL   = 4'd3,
      MODE_DIV   = 4'd4,
      MODE_MOD   = 4'd5,
      MODE_DUP   = 4'd6,
      MODE_SWAP  = 4'd7,
      MODE_CLEAR = 4'd8
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_OVERFLOW  = 3'd1,
      STATUS_UNDERFLOW = 3'd2,
      STATUS_DIVZERO   = 3'd3,
      STATUS_SAT       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_ITER,
      ST_SETTLE,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/core/rpn_stack_calculator.sv
// Reverse Polish fixed-point calculator. A command beat is taken when start is high and busy
// is low; busy then stays high until the result beat, which shows for one cycle with
// rsp_strobe and cannot be held off. The entries below the top live in a stack memory with
// one write port and a registered read; the top is kept in a register. Push, dup, clear and
// unused modes go from decode straight to the result beat; swap passes a fetch state, add
// and sub a fetch and a settle state, and mul, div and mod iterate between fetch and settle.
// Busy drops in the cycle after the strobe, so the next command may be taken then. One shared
// 33-bit adder runs one multiply or divide step per cycle. No clearing pass after reset.
module rpn_stack_calculator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rpn_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [rpn_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_strobe,
   output logic signed [rpn_pkg::DATA_W-1:0] rsp_top_value,
   output logic [rpn_pkg::DEPTH_OUT_W-1:0]   rsp_depth,
   output logic [rpn_pkg::STATUS_W-1:0]      rsp_status
);
   import rpn_pkg::*;

   state_type   state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   mode_type    mode_ff;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] top_ff, top_in;
   status_type  status_ff, status_in;
   logic [DATA_W:0]   hi_ff, hi_in;
   logic [LO_W-1:0]   lo_ff, lo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [DATA_W-1:0] stack_mem [STACK_ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [DEPTH_W-1:0] depth_m1, depth_m2;

   logic [DATA_W:0]   add_x, add_y;
   logic              add_sub;
   logic [DATA_W+1:0] add_sum;

   logic [DATA_W-1:0] opa, opb, abs_a, abs_b, int_a, int_b;
   logic              div_zero;

   logic signed [WIDE_W-1:0] prod_w, quot_w, rem_w, wide_res;
   logic              clamp_hi, clamp_lo;
   logic [DATA_W-1:0] sat_res;

   assign depth_m1 = depth_ff - DEPTH_W'(1);
   assign depth_m2 = depth_ff - DEPTH_W'(2);

   assign opa   = rd_data_ff;
   assign opb   = top_ff;
   assign abs_a = opa[DATA_W-1] ? (~opa + DATA_W'(1)) : opa;
   assign abs_b = opb[DATA_W-1] ? (~opb + DATA_W'(1)) : opb;
   assign int_a = abs_a >> FRAC_BITS;
   assign int_b = abs_b >> FRAC_BITS;

   always_comb begin
      unique case (mode_ff)
         MODE_DIV: div_zero = (opb == '0);
         MODE_MOD: div_zero = (int_b == '0);
         default:  div_zero = 1'b0;
      endcase
   end

   // shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      if (state_ff == ST_FETCH) begin
         add_x   = {opa[DATA_W-1], opa};
         add_y   = {opb[DATA_W-1], opb};
         add_sub = (mode_ff == MODE_SUB);
      end else if (state_ff == ST_ITER) begin
         if (mode_ff == MODE_MUL) begin
            add_x = {1'b0, hi_ff[DATA_W-1:0]};
            add_y = lo_ff[0] ? {1'b0, dvs_ff} : '0;
         end else begin
            add_x   = {hi_ff[DATA_W-1:0], lo_ff[LO_W-1]};
            add_y   = {1'b0, dvs_ff};
            add_sub = 1'b1;
         end
      end
   end

   assign add_sum = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y}
                  + (DATA_W+2)'(add_sub);

   // result shaping and saturation
   always_comb begin
      prod_w = {2'b00, hi_ff[DATA_W-1:0], lo_ff[DATA_W-1:0]};
      if (neg_ff) begin
         prod_w = -prod_w;
      end
      quot_w = {{(WIDE_W-LO_W){1'b0}}, lo_ff};
      if (neg_ff) begin
         quot_w = -quot_w;
      end
      rem_w = {{(WIDE_W-DATA_W){1'b0}}, hi_ff[DATA_W-1:0]};
      if (neg_ff) begin
         rem_w = -rem_w;
      end
      unique case (mode_ff)
         MODE_ADD, MODE_SUB: wide_res = {{(WIDE_W-DATA_W-1){hi_ff[DATA_W]}}, hi_ff};
         MODE_MUL:           wide_res = prod_w >>> FRAC_BITS;
         MODE_DIV:           wide_res = quot_w;
         MODE_MOD:           wide_res = rem_w <<< FRAC_BITS;
         default:            wide_res = '0;
      endcase
      clamp_hi = !wide_res[WIDE_W-1] && (wide_res[WIDE_W-2:DATA_W-1] != '0);
      clamp_lo = wide_res[WIDE_W-1] && !(&wide_res[WIDE_W-2:DATA_W-1]);
      if (clamp_hi) begin
         sat_res = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (clamp_lo) begin
         sat_res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_res = wide_res[DATA_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (mode_ff)
               MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_SWAP: begin
                  state_in = (depth_ff < DEPTH_W'(2)) ? ST_RESP : ST_FETCH;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_FETCH: begin
            unique case (mode_ff)
               MODE_ADD, MODE_SUB: state_in = ST_SETTLE;
               MODE_MUL:           state_in = ST_ITER;
               MODE_DIV, MODE_MOD: state_in = div_zero ? ST_RESP : ST_ITER;
               default:            state_in = ST_RESP;
            endcase
         end
         ST_ITER: begin
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and stack control
   always_comb begin
      depth_in  = depth_ff;
      top_in    = top_ff;
      status_in = status_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      count_in  = count_ff;
      mem_we    = 1'b0;
      mem_waddr = depth_m1[ADDR_W-1:0];
      mem_wdata = top_ff;
      unique case (state_ff)
         ST_DECODE: begin
            status_in = STATUS_OK;
            unique case (mode_ff)
               MODE_PUSH: begin
                  if (depth_ff == DEPTH_W'(STACK_ENTRIES)) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     mem_we   = (depth_ff != '0);
                     top_in   = value_ff;
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
               end
               MODE_DUP: begin
                  if (depth_ff == DEPTH_W'(STACK_ENTRIES)) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     mem_we   = (depth_ff != '0);
                     if (depth_ff == '0) begin
                        top_in = '0;
                     end
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
               end
               MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_SWAP: begin
                  if (depth_ff < DEPTH_W'(2)) begin
                     status_in = STATUS_UNDERFLOW;
                  end
               end
               MODE_CLEAR: depth_in = '0;
               default: ;
            endcase
         end
         ST_FETCH: begin
            hi_in = '0;
            unique case (mode_ff)
               MODE_ADD, MODE_SUB: hi_in = add_sum[DATA_W:0];
               MODE_MUL: begin
                  lo_in    = LO_W'(abs_b);
                  dvs_in   = abs_a;
                  neg_in   = opa[DATA_W-1] ^ opb[DATA_W-1];
                  count_in = CNT_W'(DATA_W);
               end
               MODE_DIV: begin
                  lo_in    = LO_W'(abs_a) << FRAC_BITS;
                  dvs_in   = abs_b;
                  neg_in   = opa[DATA_W-1] ^ opb[DATA_W-1];
                  count_in = CNT_W'(LO_W);
                  if (div_zero) begin
                     status_in = STATUS_DIVZERO;
                  end
               end
               MODE_MOD: begin
                  lo_in    = LO_W'(int_a);
                  dvs_in   = int_b;
                  neg_in   = opa[DATA_W-1];
                  count_in = CNT_W'(LO_W);
                  if (div_zero) begin
                     status_in = STATUS_DIVZERO;
                  end
               end
               MODE_SWAP: begin
                  mem_we    = 1'b1;
                  mem_waddr = depth_m2[ADDR_W-1:0];
                  top_in    = opa;
               end
               default: ;
            endcase
         end
         ST_ITER: begin
            count_in = count_ff - CNT_W'(1);
            if (mode_ff == MODE_MUL) begin
               hi_in = {1'b0, add_sum[DATA_W:1]};
               lo_in = {lo_ff[LO_W-1:DATA_W], add_sum[0], lo_ff[DATA_W-1:1]};
            end else begin
               hi_in = add_sum[DATA_W+1] ? {1'b0, add_sum[DATA_W-1:0]}
                                         : {1'b0, add_x[DATA_W-1:0]};
               lo_in = {lo_ff[LO_W-2:0], add_sum[DATA_W+1]};
            end
         end
         ST_SETTLE: begin
            top_in    = sat_res;
            depth_in  = depth_m1;
            status_in = (clamp_hi || clamp_lo) ? STATUS_SAT : STATUS_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
      end
      top_ff    <= top_in;
      status_ff <= status_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      count_ff  <= count_in;
   end

   // entries below the top of stack
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stack_mem[depth_m2[ADDR_W-1:0]];
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = (state_ff == ST_RESP);
   assign rsp_top_value = (depth_ff == '0) ? '0 : top_ff;
   assign rsp_depth     = DEPTH_OUT_W'(depth_ff);
   assign rsp_status    = status_ff;

endmodule

FILE: verif/rpn_result_checker.sv
module rpn_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [rpn_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [rpn_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_strobe,
   input  logic signed [rpn_pkg::DATA_W-1:0] rsp_top_value,
   input  logic [rpn_pkg::DEPTH_OUT_W-1:0]   rsp_depth,
   input  logic [rpn_pkg::STATUS_W-1:0]      rsp_status,
   output int                                error_count,
   output int                                results_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import rpn_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic [DEPTH_OUT_W-1:0]   depth;
      logic [STATUS_W-1:0]      status;
   } calc_result_type;

   logic signed [DATA_W-1:0] operand_stack [STACK_ENTRIES];
   int                       stack_level;
   calc_result_type          pending_results [$];

   function automatic logic signed [DATA_W-1:0] clamp_word(input longint x, output bit clamped);
      clamped = 1'b0;
      if (x > longint'(32'sh7FFFFFFF)) begin
         clamped = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (x < longint'(32'sh80000000)) begin
         clamped = 1'b1;
         return 32'sh80000000;
      end
      return x[DATA_W-1:0];
   endfunction

   // applies one command to the operand stack and returns the response it should produce
   function automatic calc_result_type eval_command(input logic [MODE_W-1:0] mode,
                                                     input logic signed [DATA_W-1:0] value);
      longint                   a, b, r, scale;
      bit                       computed, clamped;
      status_type               st;
      calc_result_type          res;
      logic signed [DATA_W-1:0] held;
      scale    = longint'(1) << FRAC_BITS;
      st       = STATUS_OK;
      computed = 1'b0;
      clamped  = 1'b0;
      r        = 0;
      case (mode)
         MODE_PUSH, MODE_DUP: begin
            if (stack_level >= STACK_ENTRIES) begin
               st = STATUS_OVERFLOW;
            end else begin
               if (mode == MODE_PUSH)
                  operand_stack[stack_level] = value;
               else
                  operand_stack[stack_level] = (stack_level != 0) ?
                                               operand_stack[stack_level-1] : '0;
               stack_level++;
            end
         end
         MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
            if (stack_level < 2) begin
               st = STATUS_UNDERFLOW;
            end else begin
               a = operand_stack[stack_level-2];
               b = operand_stack[stack_level-1];
               computed = 1'b1;
               case (mode)
                  MODE_ADD: r = a + b;
                  MODE_SUB: r = a - b;
                  MODE_MUL: r = (a * b) >>> FRAC_BITS;
                  MODE_DIV: begin
                     if (b == 0)
                        computed = 1'b0;
                     else
                        r = (a * scale) / b;
                  end
                  default: begin
                     if (b / scale == 0)
                        computed = 1'b0;
                     else
                        r = ((a / scale) % (b / scale)) * scale;
                  end
               endcase
               if (!computed) begin
                  st = STATUS_DIVZERO;
               end else begin
                  stack_level--;
                  operand_stack[stack_level-1] = clamp_word(r, clamped);
                  if (clamped)
                     st = STATUS_SAT;
               end
            end
         end
         MODE_SWAP: begin
            if (stack_level < 2) begin
               st = STATUS_UNDERFLOW;
            end else begin
               held = operand_stack[stack_level-1];
               operand_stack[stack_level-1] = operand_stack[stack_level-2];
               operand_stack[stack_level-2] = held;
            end
         end
         MODE_CLEAR: stack_level = 0;
         default: ;
      endcase
      res.top_value = (stack_level != 0) ? operand_stack[stack_level-1] : '0;
      res.depth     = DEPTH_OUT_W'(stack_level);
      res.status    = st;
      return res;
   endfunction

   always @(posedge clock) begin
      calc_result_type want;
      if (reset) begin
         stack_level = 0;
         pending_results.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected beat: top %h depth %0d status %0d", $time,
                        rsp_top_value, rsp_depth, rsp_status);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if ({rsp_top_value, rsp_depth, rsp_status} !== want) begin
                  $display("%0t: expected top/depth/status %h/%0d/%0d, got %h/%0d/%0d",
                           $time, want.top_value, want.depth, want.status,
                           rsp_top_value, rsp_depth, rsp_status);
                  error_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            pending_results.push_back(eval_command(req_mode, req_value));
      end
      results_due = pending_results.size();
   end

endmodule

FILE: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rpn_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [MODE_W-1:0]        req_mode;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_top_value;
   logic [DEPTH_OUT_W-1:0]   rsp_depth;
   logic [STATUS_W-1:0]      rsp_status;
   int                       error_count;
   int                       results_due;

   rpn_stack_calculator dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   rpn_result_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status),
      .error_count   (error_count),
      .results_due   (results_due)
   );

   initial clock = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_command(input logic [MODE_W-1:0] mode,
                               input logic signed [DATA_W-1:0] value, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     = 1'b1;
      req_mode  = mode;
      req_value = value;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      wait (results_due == 0);
   endtask

   function automatic logic signed [DATA_W-1:0] draw_operand();
      int sign;
      sign = $urandom_range(0, 1) ? 1 : -1;
      case ($urandom_range(0, 6))
         0: return $urandom;
         1: return sign * (int'($urandom_range(0, 200)) * 65536 + int'($urandom_range(0, 65535)));
         2: return sign > 0 ? 32'sh7FFFFFFF : 32'sh80000000;
         3: return 0;
         4: return sign * int'($urandom_range(0, 65535));
         5: return sign * (int'($urandom_range(1, 12)) << FRAC_BITS);
         default: return int'($urandom) >>> $urandom_range(4, 12);
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] draw_mode(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         return ($urandom_range(0, 4) == 0) ? MODE_DUP : MODE_PUSH;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         return MODE_CLEAR;
      if (roll < 5)
         return MODE_W'($urandom_range(9, 15));
      if (roll < 15)
         return MODE_SWAP;
      return MODE_W'($urandom_range(int'(MODE_ADD), int'(MODE_MOD)));
   endfunction

   initial begin
      int sent;
      int push_pct;
      int seg_len;
      bit idle_on;
      reset     = 1'b1;
      start     = 1'b0;
      req_mode  = MODE_PUSH;
      req_value = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corner cases
      send_command(MODE_DUP,   0, 0);
      send_command(MODE_ADD,   0, $urandom_range(0, 7));
      send_command(MODE_SWAP,  0, 0);
      send_command(MODE_CLEAR, 0, 0);
      send_command(MODE_MUL,   0, 0);
      send_command(MODE_PUSH,  32'sh7FFFFFFF, 0);
      send_command(MODE_PUSH,  32'sh7FFFFFFF, $urandom_range(0, 7));
      send_command(MODE_ADD,   0, 0);
      send_command(MODE_PUSH,  32'sh80000000, 0);
      send_command(MODE_SUB,   0, 0);
      send_command(MODE_PUSH,  32'sh80000000, 0);
      send_command(MODE_MUL,   0, $urandom_range(0, 7));
      send_command(MODE_PUSH,  0, 0);
      send_command(MODE_DIV,   0, 0);
      send_command(MODE_CLEAR, 0, 0);
      send_command(MODE_PUSH,  32'sh00038000, 0);
      send_command(MODE_PUSH,  32'shFFFE0000, 0);
      send_command(MODE_DIV,   32'shFFFFFFFF, 0);
      send_command(MODE_PUSH,  32'sh00008000, 0);
      send_command(MODE_MOD,   0, 0);
      send_command(MODE_PUSH,  32'shFFFD0000, $urandom_range(0, 7));
      send_command(MODE_MOD,   0, 0);
      send_command(MODE_PUSH,  32'shFFFF8000, 0);
      send_command(MODE_MUL,   0, 0);
      send_command(MODE_W'(9), 32'sh12345678, 0);
      send_command(MODE_W'(15), 0, 0);
      send_command(MODE_CLEAR, 0, 0);
      drain_results();

      // random segments, each with its own push bias and idle behavior
      sent = 0;
      while (sent < 1500) begin
         case ($urandom_range(0, 3))
            0: push_pct = 15;
            1: push_pct = 45;
            2: push_pct = 60;
            default: push_pct = 90;
         endcase
         if (sent == 0)
            push_pct = 90;
         seg_len = $urandom_range(40, 160);
         idle_on = ($urandom_range(0, 2) != 0);
         repeat (seg_len) begin
            send_command(draw_mode(push_pct), draw_operand(),
                         idle_on ? $urandom_range(0, 7) : 0);
            sent++;
         end
         if ($urandom_range(0, 3) == 0)
            drain_results();
      end

      drain_results();
      repeat (60) @(posedge clock);
      if (error_count == 0 && results_due == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #8000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_stack_calculator.sv
verif/rpn_result_checker.sv
verif/tb.sv
